// ===== hdl/dcqr_pkg.sv =====
// ---------------------------------------------------------------------------
// dcqr_pkg: shared types and constants for the DNS captive query responder
// Sizes of the packet store and the answer list, DNS field codes.
// ---------------------------------------------------------------------------
package dcqr_pkg;
  localparam int BufferBytes  = 512;
  localparam int MaxQuestions = 16;
  localparam int AW  = $clog2(BufferBytes);
  localparam int CW  = AW + 1;
  localparam int QW  = $clog2(MaxQuestions);
  localparam int QCW = QW + 1;

  localparam logic [15:0] FLAG_QR     = 16'h8000;
  localparam logic [15:0] FLAG_OPCODE = 16'h7800;
  localparam logic [15:0] FLAG_RESP   = 16'h8400;
  localparam logic [15:0] FLAG_RD     = 16'h0100;
  localparam logic [7:0]  LABEL_PTR   = 8'hC0;
  localparam logic [7:0]  LABEL_MAX   = 8'd63;
  localparam logic [7:0]  TTL_LOW     = 8'h3C;
  localparam logic [7:0]  PTR_HI      = 8'hC0;

  // Parser states
  typedef enum logic [13:0] {
    S_RECV  = 14'b00000000000001,
    S_HDR   = 14'b00000000000010,
    S_LAB   = 14'b00000000000100,
    S_LABW  = 14'b00000000001000,
    S_TC    = 14'b00000000010000,
    S_TCW   = 14'b00000000100000,
    S_QEND  = 14'b00000001000000,
    S_COPY  = 14'b00000010000000,
    S_COPYW = 14'b00000100000000,
    S_ANS   = 14'b00001000000000,
    S_ANSW  = 14'b00010000000000,
    S_DROP  = 14'b00100000000000,
    S_FLUSH = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } st_t;

  // Packer control
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       fin;
    logic       drop;
  } pk_t;
endpackage

// ===== hdl/dcqr_if.sv =====
// ---------------------------------------------------------------------------
// dcqr_if: valid/ready channel interfaces
// One for request bytes, one for response words.
// ---------------------------------------------------------------------------
interface dcqr_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] req_byte;
  logic       last_byte;
  modport source (output valid, req_byte, last_byte, input ready);
  modport sink (input valid, req_byte, last_byte, output ready);
endinterface

interface dcqr_resp_if;
  logic        valid;
  logic        ready;
  logic [63:0] resp_word;
  logic [3:0]  word_bytes;
  logic        last_word;
  logic        answered;
  modport source (output valid, resp_word, word_bytes, last_word, answered, input ready);
  modport sink (input valid, resp_word, word_bytes, last_word, answered, output ready);
endinterface

// ===== hdl/dcqr_packer.sv =====
// ---------------------------------------------------------------------------
// dcqr_packer: byte to word packer with output register
// Collects response bytes into left-aligned 8-byte words.
// ---------------------------------------------------------------------------
module dcqr_packer import dcqr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pk_t        pk,
  output logic       busy,
  dcqr_resp_if.source out_ch
);
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] ow_r, ow_nxt;
  logic [3:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt, oa_r, oa_nxt;

  assign busy = ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.resp_word = ow_r;
  assign out_ch.word_bytes = ob_r;
  assign out_ch.last_word = ol_r;
  assign out_ch.answered = oa_r;

  // Place a byte, emit when full or on finish; a drop emits an empty last word
  always_comb begin
    logic [63:0] a;
    logic [3:0]  c;
    a = acc_r; c = cnt_r;
    acc_nxt = acc_r; cnt_nxt = cnt_r;
    ov_nxt = ov_r && !out_ch.ready;
    ow_nxt = ow_r; ob_nxt = ob_r; ol_nxt = ol_r; oa_nxt = oa_r;
    if (pk.drop) begin
      ov_nxt = 1'b1; ow_nxt = '0; ob_nxt = '0; ol_nxt = 1'b1; oa_nxt = 1'b0;
      acc_nxt = '0; cnt_nxt = '0;
    end else if (pk.push || pk.fin) begin
      if (pk.push) begin
        a = acc_r | ({56'd0, pk.data} << (6'd56 - {cnt_r[2:0], 3'b000}));
        c = cnt_r + 4'd1;
      end
      if (c == 4'd8 || (pk.fin && c != 4'd0)) begin
        ov_nxt = 1'b1; ow_nxt = a; ob_nxt = c; ol_nxt = pk.fin; oa_nxt = 1'b1;
        acc_nxt = '0; cnt_nxt = '0;
      end else begin
        acc_nxt = a; cnt_nxt = c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; cnt_r <= '0; acc_r <= '0;
    end else begin
      ov_r <= ov_nxt; cnt_r <= cnt_nxt; acc_r <= acc_nxt;
    end
    ow_r <= ow_nxt; ob_r <= ob_nxt; ol_r <= ol_nxt; oa_r <= oa_nxt;
  end
endmodule

// ===== hdl/dcqr_parser.sv =====
// ---------------------------------------------------------------------------
// dcqr_parser: packet store and query walker
// Stores request bytes, validates the query, streams the response bytes.
// ---------------------------------------------------------------------------
module dcqr_parser import dcqr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] redirect_address,
  input  logic        pk_busy,
  output pk_t         pk,
  dcqr_req_if.sink    in_ch
);
  // Packet store and answer offset table (synchronous read)
  logic [7:0]  mem [BufferBytes];
  logic [AW:0] offs [MaxQuestions];
  logic [7:0]  rd_r;
  logic [AW:0] ord_r;

  st_t         st_r, st_nxt;
  logic [CW-1:0] len_r, len_nxt;     // stored byte count
  logic [CW-1:0] p_r, p_nxt;         // read pointer
  logic [CW-1:0] src_r, src_nxt;     // start of current question
  logic [CW-1:0] out_r, out_nxt;     // response length so far
  logic [6:0]  qd_r, qd_nxt;         // questions left
  logic [QCW-1:0] at_r, at_nxt;      // answer total
  logic [QCW-1:0] ai_r, ai_nxt;      // answer index
  logic [3:0]  k_r, k_nxt;           // byte index in header/answer/type
  logic [31:0] tc_r, tc_nxt;         // type and class bytes
  logic [7:0]  h_r [12];
  logic        hw;
  logic [AW-1:0] raddr;
  logic        oswr;
  logic [CW:0] sum;

  logic acc;
  assign in_ch.ready = (st_r == S_RECV);
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    raddr = p_nxt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (acc && len_r < CW'(BufferBytes)) mem[len_r[AW-1:0]] <= in_ch.req_byte;
    rd_r <= mem[raddr];
    if (oswr) offs[at_r[QW-1:0]] <= out_r;
    ord_r <= offs[ai_nxt[QW-1:0]];
    if (hw) h_r[k_r] <= rd_r;
  end

  // Walk the stored query and emit the response bytes
  always_comb begin
    logic [15:0] fl, ptr;
    logic [7:0]  ab;
    st_nxt = st_r; len_nxt = len_r; p_nxt = p_r; src_nxt = src_r; out_nxt = out_r;
    qd_nxt = qd_r; at_nxt = at_r; ai_nxt = ai_r; k_nxt = k_r; tc_nxt = tc_r;
    pk = '0; hw = 1'b0; oswr = 1'b0; sum = '0;
    fl = {h_r[2], h_r[3]};
    ptr = {PTR_HI, 8'd0} | {2'b00, 14'(ord_r)};
    ab = '0;
    case (st_r)
      S_RECV: begin
        p_nxt = '0;
        if (acc) begin
          if (len_r < CW'(BufferBytes)) len_nxt = len_r + 1'b1;
          if (in_ch.last_byte) begin
            k_nxt = '0; p_nxt = '0;
            st_nxt = (len_nxt < CW'(12)) ? S_DROP : S_HDR;
          end
        end
      end
      S_HDR: begin
        // rd_r holds byte p_r; capture it into slot k_r (equal to p_r)
        hw = 1'b1; k_nxt = k_r + 4'd1;
        p_nxt = p_r + 1'b1;
        if (k_r == 4'd11) begin
          p_nxt = CW'(12); src_nxt = CW'(12); out_nxt = CW'(12); at_nxt = '0;
          st_nxt = S_LABW;
        end
      end
      S_LABW: begin
        // validate header once, then wait for label read
        if (p_r == CW'(12) && src_r == CW'(12) && out_r == CW'(12) && k_r == 4'd12) begin
          qd_nxt = {h_r[4][7:0] == 8'd0 ? 7'd0 : 7'd127};
          if ((fl & FLAG_QR) != '0 || (fl & FLAG_OPCODE) != '0 ||
              ({h_r[4], h_r[5]} == 16'd0) ||
              ({h_r[4], h_r[5]} > 16'(MaxQuestions))) st_nxt = S_DROP;
          else begin
            qd_nxt = 7'(h_r[5]); k_nxt = '0; st_nxt = S_LAB;
            if (p_r >= len_r) st_nxt = S_DROP;
          end
        end else begin
          st_nxt = (p_r >= len_r) ? S_DROP : S_LAB;
        end
      end
      S_LAB: begin
        // rd_r is the label byte at p_r
        if (rd_r == 8'd0) begin
          p_nxt = p_r + 1'b1; k_nxt = '0; st_nxt = S_TCW;
        end else if ((rd_r & LABEL_PTR) == LABEL_PTR) begin
          if ({1'b0, p_r} + (CW+1)'(2) <= {1'b0, len_r}) begin
            p_nxt = p_r + 2'd2; k_nxt = '0; st_nxt = S_TCW;
          end else st_nxt = S_DROP;
        end else if ((rd_r & LABEL_PTR) != 8'd0 || rd_r > LABEL_MAX) st_nxt = S_DROP;
        else if ({1'b0, len_r - p_r} < {1'b0, CW'(rd_r)} + 1'b1) st_nxt = S_DROP;
        else begin
          p_nxt = p_r + CW'(rd_r) + 1'b1;
          st_nxt = S_LABW;
        end
      end
      S_TCW: begin
        if ({1'b0, len_r - p_r} < (CW+1)'(4)) st_nxt = S_DROP;
        else st_nxt = S_TC;
        k_nxt = '0;
      end
      S_TC: begin
        tc_nxt = {tc_r[23:0], rd_r};
        k_nxt = k_r + 4'd1;
        if (k_r != 4'd3) p_nxt = p_r + 1'b1;
        else begin
          p_nxt = p_r + 1'b1;
          st_nxt = S_QEND;
        end
      end
      S_QEND: begin
        sum = {1'b0, out_r} + {1'b0, p_r - src_r};
        if (sum > (CW+1)'(BufferBytes)) st_nxt = S_DROP;
        else begin
          if (tc_r == 32'h00010001 && at_r < QCW'(MaxQuestions)) begin
            oswr = 1'b1; at_nxt = at_r + 1'b1;
          end
          out_nxt = sum[CW-1:0];
          src_nxt = p_r;
          qd_nxt = qd_r - 1'b1;
          if (qd_r == 7'd1) begin
            // check answer room, then emit
            if ({1'b0, out_nxt} + {at_nxt, 4'd0} > (CW+1)'(BufferBytes))
              st_nxt = S_DROP;
            else begin
              k_nxt = '0; p_nxt = '0; st_nxt = S_COPY;
            end
          end else st_nxt = S_LABW;
        end
      end
      S_COPY: begin
        // header bytes from h_r, then body from memory
        if (!pk_busy) begin
          if (p_r < CW'(12)) begin
            pk.push = 1'b1;
            case (p_r[3:0])
              4'd2: pk.data = FLAG_RESP[15:8] | (fl[15:8] & FLAG_RD[15:8]);
              4'd3: pk.data = FLAG_RESP[7:0] | (fl[7:0] & FLAG_RD[7:0]);
              4'd6: pk.data = 8'(at_r >> 8);
              4'd7: pk.data = 8'(at_r);
              4'd8, 4'd9, 4'd10, 4'd11: pk.data = 8'd0;
              default: pk.data = h_r[p_r[3:0]];
            endcase
            p_nxt = p_r + 1'b1;
            if (p_nxt == CW'(12)) st_nxt = S_COPYW;
          end else begin
            pk.push = 1'b1; pk.data = rd_r;
            p_nxt = p_r + 1'b1;
            if (p_nxt == src_r) begin
              ai_nxt = '0; k_nxt = '0;
              // with no answers this byte ends the response
              if (at_r == '0) begin
                pk.fin = 1'b1; st_nxt = S_DONE;
              end else st_nxt = S_ANSW;
            end else st_nxt = S_COPYW;
          end
        end
      end
      S_COPYW: st_nxt = S_COPY;
      S_ANSW: st_nxt = S_ANS;
      S_ANS: begin
        if (!pk_busy) begin
          case (k_r)
            4'd0: ab = ptr[15:8];
            4'd1: ab = ptr[7:0];
            4'd3, 4'd5: ab = 8'd1;
            4'd9: ab = TTL_LOW;
            4'd11: ab = 8'd4;
            4'd12: ab = redirect_address[31:24];
            4'd13: ab = redirect_address[23:16];
            4'd14: ab = redirect_address[15:8];
            4'd15: ab = redirect_address[7:0];
            default: ab = 8'd0;
          endcase
          pk.push = 1'b1; pk.data = ab;
          k_nxt = k_r + 4'd1;
          if (k_r == 4'd15) begin
            ai_nxt = ai_r + 1'b1;
            // last byte of the last record ends the response
            if (ai_nxt == at_r) begin
              pk.fin = 1'b1; st_nxt = S_DONE;
            end else st_nxt = S_ANSW;
          end
        end
      end
      S_FLUSH: begin
        if (!pk_busy) begin pk.fin = 1'b1; st_nxt = S_DONE; end
      end
      S_DROP: begin
        if (!pk_busy) begin pk.drop = 1'b1; st_nxt = S_DONE; end
      end
      S_DONE: begin
        len_nxt = '0; at_nxt = '0; st_nxt = S_RECV;
      end
      default: st_nxt = S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RECV; len_r <= '0; at_r <= '0;
    end else begin
      st_r <= st_nxt; len_r <= len_nxt; at_r <= at_nxt;
    end
    p_r <= p_nxt; src_r <= src_nxt; out_r <= out_nxt; qd_r <= qd_nxt;
    ai_r <= ai_nxt; k_r <= k_nxt; tc_r <= tc_nxt;
  end
endmodule

// ===== hdl/dns_captive_query_responder_unit.sv =====
// ---------------------------------------------------------------------------
// dns_captive_query_responder_unit: captive portal DNS responder
// Answers every A/IN question with a fixed redirect address.
// ---------------------------------------------------------------------------
// Usage: query bytes enter on the in_ channel, one per transaction, with
// last_byte on the final one. Bytes past 512 are discarded. After the last
// byte the block stops taking input, checks the header, walks each question
// name out of the packet store, then streams the reply on the out_ channel
// as 8-byte words, earliest byte in the top bits; a bad query gives one
// word with answered low.
// The walk captures the header, checks it, then steps through each label
// and each name end with its type and class. Copy sends the header bytes,
// then the question bytes, then the answers; every finished word also
// holds the output register until it is taken. The packet store has a
// single read port.
// Input is taken one byte per cycle while receiving.
// Reset clears the parser to receiving an empty packet and the address to 0.
// A stalled out_ receiver holds the output register; copy and answers wait.
// cfg_we writes redirect_address; write it only while idle.
module dns_captive_query_responder_unit import dcqr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  dcqr_req_if.sink    in_ch,
  dcqr_resp_if.source out_ch
);
  logic [31:0] addr_r;
  pk_t         pk;
  logic        pk_busy;

  // Hold the redirect address
  always_ff @(posedge clk) begin
    if (!rst_n) addr_r <= '0;
    else if (cfg_we) addr_r <= cfg_wdata;
  end

  dcqr_parser u_parser (
    .clk, .rst_n, .redirect_address(addr_r), .pk_busy, .pk, .in_ch
  );
  dcqr_packer u_packer (
    .clk, .rst_n, .pk, .busy(pk_busy), .out_ch
  );
endmodule

// ===== hdl/dcqr_checker.sv =====
// ---------------------------------------------------------------------------
// dcqr_checker: port checks for the responder
// Watches the channel ports over time.
// ---------------------------------------------------------------------------
module dcqr_checker import dcqr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_bytes,
  input logic        out_last,
  input logic        out_ans
);
  // Drop results carry no bytes and end the packet
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ans |-> out_bytes == 4'd0 && out_last) else $error("drop");
  // Byte count stays in range
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ans |-> out_bytes != 4'd0 && out_bytes <= 4'd8) else $error("cnt");
  // Non-final words are full
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ans && !out_last |-> out_bytes == 4'd8) else $error("full");
  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bytes)) else $error("hold");
  // Offered request stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("in hold");
endmodule

bind dns_captive_query_responder_unit dcqr_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_bytes(out_ch.word_bytes),
  .out_last(out_ch.last_word), .out_ans(out_ch.answered)
);

// ===== test/dns_captive_query_responder_unit_tb.sv =====
// ---------------------------------------------------------------------------
// dns_captive_query_responder_unit_tb: self-checking bench for the responder
// Streams DNS query bytes in, predicts each reply burst or drop word and
// compares every response transaction field by field, under random stalls.
// ---------------------------------------------------------------------------
import dcqr_pkg::*;

typedef struct {
  logic [63:0] word;
  logic [3:0]  nbytes;
  logic        last;
  logic        ans;
} reply_word_t;

class reply_scoreboard;
  logic [7:0]  store[BufferBytes];
  logic [7:0]  reply[BufferBytes];
  int          count;
  logic [31:0] redirect;
  reply_word_t awaited[$];
  int          mismatches;
  int          words_seen;
  int          drops;

  function new();
    count = 0;
    redirect = '0;
    mismatches = 0;
    words_seen = 0;
    drops = 0;
  endfunction

  // Offset just past the name at pos, or -1 when the name is malformed
  function int name_stop(int pos, int len);
    int lab;
    while (pos < len) begin
      lab = store[pos];
      if (lab == 0) return pos + 1;
      if ((lab & LABEL_PTR) == LABEL_PTR) return (pos + 2 <= len) ? pos + 2 : -1;
      if ((lab & LABEL_PTR) != 0 || lab > LABEL_MAX) return -1;
      if (len - pos < lab + 1) return -1;
      pos += lab + 1;
    end
    return -1;
  endfunction

  // Build the reply bytes; 0 means drop
  function int build_reply();
    int len, qd, src, dst, ne, qlen, total;
    int offs[MaxQuestions];
    logic [15:0] flags, qtype, qclass, ptr;
    len = count;
    if (len < 12) return 0;
    flags = {store[2], store[3]};
    qd = {store[4], store[5]};
    if ((flags & FLAG_QR) != 0 || (flags & FLAG_OPCODE) != 0 || qd == 0 || qd > MaxQuestions)
      return 0;
    for (int i = 0; i < 12; i++) reply[i] = 8'h00;
    reply[0] = store[0];
    reply[1] = store[1];
    flags = FLAG_RESP | (flags & FLAG_RD);
    reply[2] = flags[15:8];
    reply[3] = flags[7:0];
    reply[4] = store[4];
    reply[5] = store[5];
    src = 12;
    dst = 12;
    total = 0;
    for (int i = 0; i < qd; i++) begin
      ne = name_stop(src, len);
      if (ne < 0) return 0;
      if (len - ne < 4) return 0;
      qtype = {store[ne], store[ne+1]};
      qclass = {store[ne+2], store[ne+3]};
      qlen = ne + 4 - src;
      if (dst + qlen > BufferBytes) return 0;
      for (int k = 0; k < qlen; k++) reply[dst+k] = store[src+k];
      if (qtype == 16'd1 && qclass == 16'd1 && total < MaxQuestions) begin
        offs[total] = dst;
        total++;
      end
      dst += qlen;
      src = ne + 4;
    end
    // Append one A record per A/IN question
    for (int i = 0; i < total; i++) begin
      if (dst + 16 > BufferBytes) return 0;
      ptr = {PTR_HI, 8'h00} | 16'(offs[i] & 16'h3FFF);
      reply[dst+0] = ptr[15:8];
      reply[dst+1] = ptr[7:0];
      reply[dst+2] = 8'h00; reply[dst+3] = 8'h01;
      reply[dst+4] = 8'h00; reply[dst+5] = 8'h01;
      reply[dst+6] = 8'h00; reply[dst+7] = 8'h00;
      reply[dst+8] = 8'h00; reply[dst+9] = TTL_LOW;
      reply[dst+10] = 8'h00; reply[dst+11] = 8'h04;
      reply[dst+12] = redirect[31:24];
      reply[dst+13] = redirect[23:16];
      reply[dst+14] = redirect[15:8];
      reply[dst+15] = redirect[7:0];
      dst += 16;
    end
    reply[6] = 8'h00;
    reply[7] = total[7:0];
    return dst;
  endfunction

  // Note an accepted query byte; on the last one queue the reply words
  function void note_byte(logic [7:0] b, logic last);
    int rlen, cnt;
    reply_word_t w;
    if (count < BufferBytes) begin
      store[count] = b;
      count++;
    end
    if (!last) return;
    rlen = build_reply();
    if (rlen == 0) begin
      w.word = '0; w.nbytes = '0; w.last = 1'b1; w.ans = 1'b0;
      awaited.push_back(w);
    end else begin
      for (int pos = 0; pos < rlen; pos += 8) begin
        cnt = (rlen - pos > 8) ? 8 : rlen - pos;
        w.word = '0;
        for (int k = 0; k < cnt; k++) w.word[63-8*k -: 8] = reply[pos+k];
        w.nbytes = 4'(cnt);
        w.last = (pos + 8 >= rlen);
        w.ans = 1'b1;
        awaited.push_back(w);
      end
    end
    count = 0;
  endfunction

  // Compare a received response transaction with the oldest expectation
  function void check_word(reply_word_t got);
    reply_word_t exp;
    words_seen++;
    if (!got.ans) drops++;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response word %h", got.word);
      return;
    end
    exp = awaited.pop_front();
    if (got.word !== exp.word || got.nbytes !== exp.nbytes ||
        got.last !== exp.last || got.ans !== exp.ans) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                 exp.word, exp.nbytes, exp.last, exp.ans,
                 got.word, got.nbytes, got.last, got.ans);
    end
  endfunction
endclass

module dns_captive_query_responder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  typedef enum int {Q_LABELS, Q_PTR, Q_LONG63, Q_BAD01, Q_BAD10} qkind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        long_hold = 1'b0;
  logic        quiet = 1'b0;
  int          idle_cycles = 0;
  int          packets = 0;
  logic [7:0]  pkt[$];
  reply_scoreboard sb = new();

  dcqr_req_if  req();
  dcqr_resp_if rsp();

  dns_captive_query_responder_unit DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(req), .out_ch(rsp)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.req_byte = '0;
    req.last_byte = 1'b0;
    rsp.ready = 1'b0;
  end

  // Receive response transactions with random or long stalls
  initial begin
    reply_word_t got;
    int n;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      n = quiet ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      got.word = rsp.resp_word;
      got.nbytes = rsp.word_bytes;
      got.last = rsp.last_word;
      got.ans = rsp.answered;
      sb.check_word(got);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("watchdog expired");
        $display("dns_captive_query_responder_unit_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic write_redirect(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.redirect = v;
  endtask

  // Stop offering, hold until every expected word has come, then settle
  task automatic drain();
    req.valid <= 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offer the packet bytes one transaction at a time
  task automatic send_packet();
    int gap;
    for (int i = 0; i < pkt.size(); i++) begin
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req.valid <= 1'b1;
      req.req_byte <= pkt[i];
      req.last_byte <= (i == pkt.size() - 1);
      do @(posedge clk); while (!req.ready);
      sb.note_byte(pkt[i], i == pkt.size() - 1);
    end
    packets++;
  endtask

  task automatic put_header(int qd, logic [15:0] flags);
    pkt.delete();
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(flags[15:8]);
    pkt.push_back(flags[7:0]);
    pkt.push_back(8'(qd >> 8));
    pkt.push_back(8'(qd));
    repeat (6) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] good_flags();
    return 16'($urandom_range(0, 16'hFFFF)) & ~(FLAG_QR | FLAG_OPCODE);
  endfunction

  // Append one question name of the given kind, then type and class
  task automatic put_question(qkind_t kind, int lablen, logic a_in);
    int nlab;
    case (kind)
      Q_PTR: begin
        pkt.push_back(LABEL_PTR | 8'($urandom_range(0, 63)));
        pkt.push_back(8'($urandom_range(0, 255)));
      end
      Q_LONG63: begin
        pkt.push_back(LABEL_MAX);
        repeat (63) pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'h00);
      end
      Q_BAD01: begin
        pkt.push_back(8'h40 | 8'($urandom_range(0, 63)));
        pkt.push_back(8'h00);
      end
      Q_BAD10: begin
        pkt.push_back(8'h80 | 8'($urandom_range(0, 63)));
        pkt.push_back(8'h00);
      end
      default: begin
        nlab = (lablen > 0) ? 1 : $urandom_range(0, 3);
        repeat (nlab) begin
          int l;
          l = (lablen > 0) ? lablen : $urandom_range(1, 8);
          pkt.push_back(8'(l));
          repeat (l) pkt.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0 && lablen == 0) begin
          pkt.push_back(LABEL_PTR | 8'($urandom_range(0, 63)));
          pkt.push_back(8'($urandom_range(0, 255)));
        end else begin
          pkt.push_back(8'h00);
        end
      end
    endcase
    if (a_in) begin
      pkt.push_back(8'h00); pkt.push_back(8'h01);
      pkt.push_back(8'h00); pkt.push_back(8'h01);
    end else begin
      repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_query();
    int qd, mode;
    qd = $urandom_range(1, 2);
    put_header(qd, good_flags());
    for (int i = 0; i < qd; i++)
      put_question(($urandom_range(0, 5) == 0) ? Q_PTR : Q_LABELS, 0,
                   $urandom_range(0, 9) < 7);
    mode = $urandom_range(0, 9);
    // Break a minority of queries: cut short, bad header, pure noise, or an extra byte
    if (mode == 0) begin
      void'($urandom);
      while (pkt.size() > 1 && $urandom_range(0, 3) != 0) void'(pkt.pop_back());
    end else if (mode == 1) begin
      pkt[2] = pkt[2] | (8'h80 >> $urandom_range(0, 4));
    end else if (mode == 2) begin
      pkt.delete();
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom_range(0, 255)));
    end else if (mode == 3) begin
      pkt.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_redirect($urandom);

    // Directed: short payload
    pkt.delete(); pkt.push_back(8'hFF); send_packet();
    // Plain A/IN query with RD set
    put_header(1, FLAG_RD); put_question(Q_LABELS, 3, 1); send_packet();
    // Header reject: response bit
    put_header(1, FLAG_QR); put_question(Q_PTR, 0, 1); send_packet();
    // Bad label top bits
    put_header(1, good_flags()); put_question(Q_BAD10, 0, 1); send_packet();
    // Pointer name, then a non-A question
    put_header(2, good_flags()); put_question(Q_PTR, 0, 1);
    put_question(Q_LABELS, 2, 0); send_packet();
    drain();
    write_redirect(32'hFFFF_FFFF);

    // Random queries: first under a long receiver hold, then back to back
    for (int n = 0; n < 2; n++) begin
      quiet = (n == 1);
      if (n == 0) long_hold = 1'b1;
      random_query();
      send_packet();
    end
    req.last_byte <= 1'b0;
    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d queries, %0d response words, %0d dropped queries",
             packets, sb.words_seen, sb.drops);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("dns_captive_query_responder_unit_tb OK");
    end else begin
      $display("%0d mismatches, %0d words missing", sb.mismatches, sb.awaited.size());
      $display("dns_captive_query_responder_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
